// ----- src/bspq_pkg.sv -----
// shared types and constants for the bounded sorted priority queue
// used by bspq_cell and bounded_sorted_priority_queue; no dependencies
package bspq_pkg;

  localparam int MODE_W  = 2;
  localparam int VALUE_W = 32;
  localparam int PRIO_W  = 16;
  localparam int STAT_W  = 2;
  localparam int CNT_W   = 5;
  localparam int CAP_W   = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // operation codes carried in the mode field
  localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POP   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    logic signed [VALUE_W-1:0] push_value;
    logic signed [PRIO_W-1:0]  push_priority;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]         status;
    logic signed [VALUE_W-1:0] popped_value;
    logic signed [PRIO_W-1:0]  popped_priority;
    logic                      head_valid;
    logic signed [VALUE_W-1:0] head_value;
    logic signed [PRIO_W-1:0]  head_priority;
    logic [CNT_W-1:0]          entry_count;
  } out_item_t;

  // one queue slot
  typedef struct packed {
    logic                      vld;
    logic signed [VALUE_W-1:0] value;
    logic signed [PRIO_W-1:0]  prio;
  } entry_t;

  localparam entry_t ENT_EMPTY = '0;

  // operation broadcast to every cell, already qualified by full and empty
  typedef enum logic [1:0] {
    OP_NONE,
    OP_PUSH,
    OP_POP,
    OP_CLEAR
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    entry_t   new_ent;
  } cell_cmd_t;

endpackage

// ----- src/bspq_cell.sv -----
// one slot of the sorted queue: holds an entry, shifts right on push, left on pop
// depends on bspq_pkg
module bspq_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  bspq_pkg::cell_cmd_t cmd,
  input  bspq_pkg::entry_t   left_ent,
  input  logic               left_beat,
  input  bspq_pkg::entry_t   right_ent,
  output bspq_pkg::entry_t   ent_r,
  output bspq_pkg::entry_t   ent_nxt,
  output logic               beat
);
  import bspq_pkg::*;

  // new entry goes at or before this slot: slot is empty or strictly lower priority
  assign beat = !ent_r.vld || (ent_r.prio < cmd.new_ent.prio);

  always_comb begin
    ent_nxt = ent_r;
    case (cmd.op)
      OP_PUSH: begin
        if (left_beat) begin
          ent_nxt = left_ent;
        end else if (beat) begin
          ent_nxt = cmd.new_ent;
        end
      end
      OP_POP:   ent_nxt = right_ent;
      OP_CLEAR: ent_nxt.vld = 1'b0;
      default:  ent_nxt = ent_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.vld <= 1'b0;
    end else begin
      ent_r.vld <= ent_nxt.vld;
    end
    ent_r.value <= ent_nxt.value;
    ent_r.prio  <= ent_nxt.prio;
  end

endmodule

// ----- src/bounded_sorted_priority_queue.sv -----
// bounded sorted priority queue: one push, pop or clear per cycle unless in_stall is high,
// result registered and shown in the cycle after the transaction is accepted
// every cell compares against the pushed priority at once and shifts in the same cycle
// reset: empty queue, capacity 16, no result pending; entry payloads are not cleared
// depends on bspq_pkg and bspq_cell
module bounded_sorted_priority_queue #(
  parameter int DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bspq_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output bspq_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [bspq_pkg::CAP_W-1:0] cfg_data
);
  import bspq_pkg::*;

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

  logic [CAP_W-1:0] cap_r;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic             acc;
  logic             full, empty;
  cell_cmd_t        cmd;

  entry_t ent_r_a   [DEPTH];
  entry_t ent_nxt_a [DEPTH];
  logic   beat_a    [DEPTH];

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall;
  assign acc       = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign full  = (CMPW'(cnt_r) >= CMPW'(cap_r)) || (CMPW'(cnt_r) >= CMPW'(DEPTH));
  assign empty = (cnt_r == '0);

  always_comb begin
    cmd.new_ent.vld   = 1'b1;
    cmd.new_ent.value = in_data.push_value;
    cmd.new_ent.prio  = in_data.push_priority;
    cmd.op            = OP_NONE;
    if (acc) begin
      unique case (in_data.mode)
        MODE_PUSH:  cmd.op = full ? OP_NONE : OP_PUSH;
        MODE_POP:   cmd.op = empty ? OP_NONE : OP_POP;
        MODE_CLEAR: cmd.op = OP_CLEAR;
        default:    cmd.op = OP_NONE;
      endcase
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_ent, right_ent;
    logic   left_beat;

    if (i == 0) begin : g_first
      assign left_ent  = ENT_EMPTY;
      assign left_beat = 1'b0;
    end else begin : g_mid
      assign left_ent  = ent_r_a[i-1];
      assign left_beat = beat_a[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_ent = ENT_EMPTY;
    end else begin : g_inner
      assign right_ent = ent_r_a[i+1];
    end

    bspq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .left_ent  (left_ent),
      .left_beat (left_beat),
      .right_ent (right_ent),
      .ent_r     (ent_r_a[i]),
      .ent_nxt   (ent_nxt_a[i]),
      .beat      (beat_a[i])
    );
  end

  always_comb begin
    cnt_nxt = cnt_r;
    case (cmd.op)
      OP_PUSH:  cnt_nxt = cnt_r + CW'(1);
      OP_POP:   cnt_nxt = cnt_r - CW'(1);
      OP_CLEAR: cnt_nxt = '0;
      default:  cnt_nxt = cnt_r;
    endcase
  end

  always_comb begin
    out_data_nxt = '0;
    if (acc && in_data.mode == MODE_PUSH && full) begin
      out_data_nxt.status = STAT_FULL;
    end else if (acc && in_data.mode == MODE_POP && empty) begin
      out_data_nxt.status = STAT_EMPTY;
    end else begin
      out_data_nxt.status = STAT_DONE;
    end
    if (cmd.op == OP_POP) begin
      out_data_nxt.popped_value    = ent_r_a[0].value;
      out_data_nxt.popped_priority = ent_r_a[0].prio;
    end
    // head is taken from the slot 0 value after this transaction
    if (ent_nxt_a[0].vld) begin
      out_data_nxt.head_valid    = 1'b1;
      out_data_nxt.head_value    = ent_nxt_a[0].value;
      out_data_nxt.head_priority = ent_nxt_a[0].prio;
    end
    out_data_nxt.entry_count = CNT_W'(cnt_nxt);
  end

  always_comb begin
    if (acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (acc) begin
      out_data_r <= out_data_nxt;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMPW'(cnt_r) <= CMPW'(DEPTH))
    else $error("entry count above depth");

  a_head_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    ent_r_a[0].vld == (cnt_r != '0))
    else $error("head slot valid disagrees with count");

  a_full_holds_count: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_data.mode == MODE_PUSH && full |=> cnt_r == $past(cnt_r))
    else $error("dropped push changed the count");

  a_result_count: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_valid_r && out_data_r.head_valid == (cnt_r != '0))
    else $error("result head valid disagrees with count");
`endif

endmodule

// ----- tb/bounded_sorted_priority_queue_test.sv -----
`timescale 1ns / 100ps
// testbench for bounded_sorted_priority_queue: directed and random push, pop and clear
// transactions checked against an in-bench sorted queue model; depends on bspq_pkg and bounded_sorted_priority_queue
module bounded_sorted_priority_queue_test;
  import bspq_pkg::*;

  localparam int DEPTH = 16;
  localparam int QUIET_LIMIT = 3000;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CAP_W-1:0] cfg_data = '0;

  bounded_sorted_priority_queue #(.DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  // shadow copy of the sorted queue, slot 0 is the head
  logic signed [VALUE_W-1:0] shadow_value [DEPTH];
  logic signed [PRIO_W-1:0]  shadow_prio [DEPTH];
  int shadow_count = 0;
  logic [CAP_W-1:0] shadow_cap = CAP_RESET;

  in_item_t  pending_ops[$];
  out_item_t expected_results[$];
  int queued_ops = 0;
  int accepted_ops = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit in_fire = 1'b0;
  bit out_fire = 1'b0;
  bit cfg_fire = 1'b0;

  function automatic out_item_t predict_queue_step(input in_item_t op);
    out_item_t res;
    int limit;
    int pos;
    int i;
    res = '0;
    limit = (shadow_cap > DEPTH) ? DEPTH : int'(shadow_cap);
    case (op.mode)
      MODE_PUSH: begin
        if (shadow_count >= limit) begin
          res.status = STAT_FULL;
        end else begin
          // new entry goes behind all entries of equal or higher priority
          pos = 0;
          while (pos < shadow_count && shadow_prio[pos] >= $signed(op.push_priority))
            pos++;
          for (i = shadow_count; i > pos; i--) begin
            shadow_value[i] = shadow_value[i-1];
            shadow_prio[i] = shadow_prio[i-1];
          end
          shadow_value[pos] = op.push_value;
          shadow_prio[pos] = op.push_priority;
          shadow_count++;
        end
      end
      MODE_POP: begin
        if (shadow_count == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          res.popped_value = shadow_value[0];
          res.popped_priority = shadow_prio[0];
          for (i = 1; i < shadow_count; i++) begin
            shadow_value[i-1] = shadow_value[i];
            shadow_prio[i-1] = shadow_prio[i];
          end
          shadow_count--;
        end
      end
      MODE_CLEAR: shadow_count = 0;
      default: ;
    endcase
    if (shadow_count > 0) begin
      res.head_valid = 1'b1;
      res.head_value = shadow_value[0];
      res.head_priority = shadow_prio[0];
    end
    res.entry_count = CNT_W'(shadow_count);
    return res;
  endfunction

  task automatic check_result(input out_item_t got, input out_item_t want);
    string bad;
    bad = "";
    if (got.status !== want.status) bad = {bad, " status"};
    if (got.popped_value !== want.popped_value) bad = {bad, " popped_value"};
    if (got.popped_priority !== want.popped_priority) bad = {bad, " popped_priority"};
    if (got.head_valid !== want.head_valid) bad = {bad, " head_valid"};
    if (got.head_value !== want.head_value) bad = {bad, " head_value"};
    if (got.head_priority !== want.head_priority) bad = {bad, " head_priority"};
    if (got.entry_count !== want.entry_count) bad = {bad, " entry_count"};
    if (bad != "") begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch on%s", bad);
        $display("  expected st=%0d pop=%0d/%0d head=%0b %0d/%0d cnt=%0d", want.status,
                 $signed(want.popped_value), $signed(want.popped_priority), want.head_valid,
                 $signed(want.head_value), $signed(want.head_priority), want.entry_count);
        $display("  actual   st=%0d pop=%0d/%0d head=%0b %0d/%0d cnt=%0d", got.status,
                 $signed(got.popped_value), $signed(got.popped_priority), got.head_valid,
                 $signed(got.head_value), $signed(got.head_priority), got.entry_count);
      end
    end
  endtask

  // driver: a new transaction goes out once the previous one is taken
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fire)) begin
      if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data <= pending_ops.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_idle_pct);

  // monitor: check results, predict accepted transactions, track config writes
  always @(posedge clk) begin
    in_fire = rst_n && in_valid && !in_stall;
    out_fire = rst_n && out_valid && !out_stall;
    cfg_fire = rst_n && cfg_valid && cfg_ready;
    if (out_fire) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: st=%0d cnt=%0d", out_data.status, out_data.entry_count);
      end else begin
        check_result(out_data, expected_results.pop_front());
      end
    end
    if (in_fire) begin
      expected_results.push_back(predict_queue_step(in_data));
      accepted_ops++;
    end
    if (cfg_fire) shadow_cap = cfg_data;
    if (in_fire || out_fire || cfg_fire) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("bounded_sorted_priority_queue test failed");
        $finish;
      end
    end
  end

  task automatic queue_op(input logic [MODE_W-1:0] mode, input logic [VALUE_W-1:0] value,
                          input logic [PRIO_W-1:0] prio);
    in_item_t op;
    op.mode = mode;
    op.push_value = value;
    op.push_priority = prio;
    pending_ops.push_back(op);
    queued_ops++;
  endtask

  task automatic wait_for_idle();
    do @(negedge clk); while (accepted_ops != queued_ops || expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    wait_for_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= cap;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // half the picks come from a narrow band so equal priorities are common
  function automatic logic [PRIO_W-1:0] pick_priority();
    int sel;
    logic [PRIO_W-1:0] p;
    sel = $urandom_range(9);
    if (sel < 5) begin
      p = PRIO_W'($urandom_range(6)) - PRIO_W'(3);
    end else if (sel < 7) begin
      case ($urandom_range(3))
        0: p = 16'h7fff;
        1: p = 16'h8000;
        2: p = 16'h0000;
        default: p = 16'hffff;
      endcase
    end else begin
      p = PRIO_W'($urandom);
    end
    return p;
  endfunction

  task automatic queue_random_ops(input int count, input int push_pct);
    int roll;
    int n;
    for (n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < push_pct) queue_op(MODE_PUSH, $urandom, pick_priority());
      else if (roll == 99) queue_op(MODE_CLEAR, $urandom, PRIO_W'($urandom));
      else if (roll == 98) queue_op(MODE_UNUSED, $urandom, PRIO_W'($urandom));
      else queue_op(MODE_POP, $urandom, PRIO_W'($urandom));
    end
  endtask

  initial begin
    send_idle_pct = 25;
    recv_idle_pct = 72;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queue corners, extremes, ties at reset capacity
    queue_op(MODE_POP, 32'h0, 16'h0);
    queue_op(MODE_UNUSED, 32'hffffffff, 16'hffff);
    queue_op(MODE_CLEAR, 32'h0, 16'h0);
    queue_op(MODE_PUSH, 32'h7fffffff, 16'h7fff);
    queue_op(MODE_PUSH, 32'h80000000, 16'h8000);
    queue_op(MODE_PUSH, 32'h1, 16'h0);
    queue_op(MODE_PUSH, 32'h2, 16'h0);
    queue_op(MODE_PUSH, 32'hffffffff, 16'hffff);
    queue_op(MODE_UNUSED, 32'h0, 16'h0);
    queue_op(MODE_POP, 32'h0, 16'h0);
    queue_op(MODE_POP, 32'h0, 16'h0);
    queue_op(MODE_CLEAR, 32'h0, 16'h0);

    // push into a full queue
    set_capacity(5'd2);
    queue_op(MODE_PUSH, 32'h5, 16'h5);
    queue_op(MODE_PUSH, 32'h6, 16'h5);
    queue_op(MODE_PUSH, 32'h7, 16'h9);
    queue_op(MODE_POP, 32'h0, 16'h0);

    // zero capacity drops every push
    set_capacity(5'd0);
    queue_op(MODE_PUSH, 32'h8, 16'h1);
    queue_op(MODE_POP, 32'h0, 16'h0);
    queue_op(MODE_POP, 32'h0, 16'h0);

    // capacity above depth saturates
    set_capacity(5'd31);
    queue_op(MODE_PUSH, 32'h11, 16'h1);
    queue_op(MODE_PUSH, 32'h12, 16'h2);
    queue_op(MODE_PUSH, 32'h13, 16'h3);

    // capacity lowered below the count
    set_capacity(5'd1);
    queue_op(MODE_PUSH, 32'h14, 16'h4);
    queue_op(MODE_POP, 32'h0, 16'h0);
    queue_op(MODE_POP, 32'h0, 16'h0);
    queue_op(MODE_POP, 32'h0, 16'h0);
    queue_op(MODE_PUSH, 32'h15, 16'h5);

    set_capacity(5'd16);
    queue_random_ops(200, 65);
    set_capacity(5'd5);
    queue_random_ops(120, 55);

    set_capacity(5'd31);
    send_idle_pct = 72;
    recv_idle_pct = 25;
    queue_random_ops(200, 70);
    set_capacity(5'd0);
    queue_random_ops(30, 50);
    set_capacity(5'd1);
    queue_random_ops(80, 50);

    set_capacity(5'd16);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_ops(250, 60);
    set_capacity(5'd12);
    queue_random_ops(150, 62);
    // queue likely holds more than the new capacity here
    set_capacity(5'd3);
    queue_random_ops(120, 45);

    wait_for_idle();
    if (mismatches == 0) begin
      $display("bounded_sorted_priority_queue test passed");
    end else begin
      $display("bounded_sorted_priority_queue test failed");
    end
    $finish;
  end

endmodule
